// ===== rtl/gdd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdd_pkg
// Shared types, microcode encoding and calendar tables for the date difference
// sequencer.
// ----------------------------------------------------------------------------
package gdd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 22;
  localparam int ACC_W   = 24;   // signed difference of two day serials
  localparam int TERM_W  = 23;   // one unsigned serial term
  localparam int MUL_A_W = 15;
  localparam int MUL_K_W = 13;
  localparam int PROD_W  = MUL_A_W + MUL_K_W;
  localparam int QUOT_W  = 8;    // floor(year / 100) and friends stay below 256
  localparam int STEP_W  = 5;

  // address of the final control word
  localparam logic [STEP_W-1:0] STEP_FIN = 5'd16;

  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x below 2**15
  localparam logic [MUL_K_W-1:0] RECIP_100   = 13'd5243;
  localparam int                 RECIP_SHIFT = 19;
  localparam logic [MUL_K_W-1:0] DAYS_YEAR   = 13'd365;
  localparam logic [MUL_K_W-1:0] HUNDRED     = 13'd100;

  localparam logic [ACC_W-1:0] COUNT_MAX = 24'd4194303;

  // datapath operations
  localparam logic [2:0] OP_YQ     = 3'd0;  // t = year / 100
  localparam logic [2:0] OP_LEAP   = 3'd1;  // leap flag from year and t
  localparam logic [2:0] OP_MON    = 3'd2;  // check date, add day of year
  localparam logic [2:0] OP_Y365   = 3'd3;  // add 365*y + (y+3)/4
  localparam logic [2:0] OP_DIV100 = 3'd4;  // t = (y+99) / 100
  localparam logic [2:0] OP_DIV400 = 3'd5;  // t = (y+399) / 400
  localparam logic [2:0] OP_ACCT   = 3'd6;  // add t
  localparam logic [2:0] OP_FIN    = 3'd7;  // hand result to output stage

  // jump conditions
  localparam logic JC_NEXT = 1'b0;
  localparam logic JC_BAD  = 1'b1;

  localparam logic SEL_START = 1'b0;
  localparam logic SEL_END   = 1'b1;

  typedef struct packed {
    logic [2:0]        op;
    logic              sel;     // which date the step works on
    logic              neg;     // subtract instead of add
    logic              jc;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    begin
      case (m)
        4'd2: len = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
        default: len = 5'd0;
      endcase
      return len;
    end
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    begin
      case (m)
        4'd1:  d = 9'd0;
        4'd2:  d = 9'd31;
        4'd3:  d = 9'd59;
        4'd4:  d = 9'd90;
        4'd5:  d = 9'd120;
        4'd6:  d = 9'd151;
        4'd7:  d = 9'd181;
        4'd8:  d = 9'd212;
        4'd9:  d = 9'd243;
        4'd10: d = 9'd273;
        4'd11: d = 9'd304;
        4'd12: d = 9'd334;
        default: d = 9'd0;
      endcase
      return d;
    end
  endfunction

endpackage

// ===== rtl/gdd_ucode_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdd_ucode_rom
// Microprogram for the date difference: serial(end) - serial(start).
// ----------------------------------------------------------------------------
module gdd_ucode_rom (
  input  logic [gdd_pkg::STEP_W-1:0] step,
  output gdd_pkg::uword_t            uword
);

  function automatic gdd_pkg::uword_t uw(input logic [2:0] op, input logic sel,
                                         input logic neg);
    gdd_pkg::uword_t w;
    begin
      w.op     = op;
      w.sel    = sel;
      w.neg    = neg;
      w.jc     = gdd_pkg::JC_NEXT;
      w.target = '0;
      return w;
    end
  endfunction

  always_comb begin
    unique case (step)
      // validity and day of year for both dates
      5'd0:  uword = uw(gdd_pkg::OP_YQ,     gdd_pkg::SEL_START, 1'b0);
      5'd1:  uword = uw(gdd_pkg::OP_LEAP,   gdd_pkg::SEL_START, 1'b0);
      5'd2:  uword = uw(gdd_pkg::OP_MON,    gdd_pkg::SEL_START, 1'b1);
      5'd3:  uword = uw(gdd_pkg::OP_YQ,     gdd_pkg::SEL_END,   1'b0);
      5'd4:  uword = uw(gdd_pkg::OP_LEAP,   gdd_pkg::SEL_END,   1'b0);
      5'd5:  uword = uw(gdd_pkg::OP_MON,    gdd_pkg::SEL_END,   1'b0);
      // year part of start serial, skip everything on a bad date
      5'd6: begin
        uword        = uw(gdd_pkg::OP_Y365, gdd_pkg::SEL_START, 1'b1);
        uword.jc     = gdd_pkg::JC_BAD;
        uword.target = gdd_pkg::STEP_FIN;
      end
      5'd7:  uword = uw(gdd_pkg::OP_DIV100, gdd_pkg::SEL_START, 1'b0);
      5'd8:  uword = uw(gdd_pkg::OP_ACCT,   gdd_pkg::SEL_START, 1'b0);
      5'd9:  uword = uw(gdd_pkg::OP_DIV400, gdd_pkg::SEL_START, 1'b0);
      5'd10: uword = uw(gdd_pkg::OP_ACCT,   gdd_pkg::SEL_START, 1'b1);
      // year part of end serial
      5'd11: uword = uw(gdd_pkg::OP_Y365,   gdd_pkg::SEL_END,   1'b0);
      5'd12: uword = uw(gdd_pkg::OP_DIV100, gdd_pkg::SEL_END,   1'b0);
      5'd13: uword = uw(gdd_pkg::OP_ACCT,   gdd_pkg::SEL_END,   1'b1);
      5'd14: uword = uw(gdd_pkg::OP_DIV400, gdd_pkg::SEL_END,   1'b0);
      5'd15: uword = uw(gdd_pkg::OP_ACCT,   gdd_pkg::SEL_END,   1'b0);
      default: uword = uw(gdd_pkg::OP_FIN,  gdd_pkg::SEL_START, 1'b0);
    endcase
  end

endmodule

// ===== rtl/gdd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdd_datapath
// Accumulator, one shared constant multiplier and date checks, driven by the
// control word of the current step.
// ----------------------------------------------------------------------------
module gdd_datapath (
  input  logic                          clk,
  input  logic                          init,      // new item captured
  input  logic                          exec,      // execute uword this cycle
  input  gdd_pkg::uword_t               uword,
  input  gdd_pkg::date_t                start_date,
  input  gdd_pkg::date_t                end_date,
  input  logic                          include_end_day,
  output logic                          bad,
  output logic [gdd_pkg::COUNT_W-1:0]   count
);

  logic signed [gdd_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [gdd_pkg::QUOT_W-1:0]        t_r, t_nxt;
  logic                              leap_r, leap_nxt;
  logic                              bad_r, bad_nxt;

  gdd_pkg::date_t                    cur;
  logic [gdd_pkg::MUL_A_W-1:0]       mul_a;
  logic [gdd_pkg::MUL_K_W-1:0]       mul_k;
  logic [gdd_pkg::PROD_W-1:0]        prod;
  logic [gdd_pkg::MUL_A_W-1:0]       y_plus_99;
  logic [gdd_pkg::MUL_A_W-1:0]       y_plus_399;
  logic [gdd_pkg::TERM_W-1:0]        term;
  logic                              add_en;
  logic                              date_ok;
  logic [gdd_pkg::DAY_W-1:0]         len;
  logic [gdd_pkg::ACC_W-1:0]         pos_diff;
  logic [gdd_pkg::ACC_W-1:0]         sum;

  assign cur        = uword.sel ? end_date : start_date;
  assign y_plus_99  = {1'b0, cur.year} + 15'd99;
  assign y_plus_399 = {1'b0, cur.year} + 15'd399;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_k = '0;
    case (uword.op)
      gdd_pkg::OP_YQ: begin
        mul_a = {1'b0, cur.year};
        mul_k = gdd_pkg::RECIP_100;
      end
      gdd_pkg::OP_LEAP: begin
        mul_a = {{(gdd_pkg::MUL_A_W-gdd_pkg::QUOT_W){1'b0}}, t_r};
        mul_k = gdd_pkg::HUNDRED;
      end
      gdd_pkg::OP_Y365: begin
        mul_a = {1'b0, cur.year};
        mul_k = gdd_pkg::DAYS_YEAR;
      end
      gdd_pkg::OP_DIV100: begin
        mul_a = y_plus_99;
        mul_k = gdd_pkg::RECIP_100;
      end
      gdd_pkg::OP_DIV400: begin
        mul_a = {2'b00, y_plus_399[gdd_pkg::MUL_A_W-1:2]};
        mul_k = gdd_pkg::RECIP_100;
      end
      default: begin
        mul_a = '0;
        mul_k = '0;
      end
    endcase
  end

  assign prod = gdd_pkg::PROD_W'(mul_a) * gdd_pkg::PROD_W'(mul_k);

  assign len     = gdd_pkg::month_len(cur.month, leap_r);
  assign date_ok = (cur.day != '0) && (cur.day <= len);

  always_comb begin
    acc_nxt  = acc_r;
    t_nxt    = t_r;
    leap_nxt = leap_r;
    bad_nxt  = bad_r;
    term     = '0;
    add_en   = 1'b0;
    case (uword.op)
      gdd_pkg::OP_YQ, gdd_pkg::OP_DIV100, gdd_pkg::OP_DIV400: begin
        t_nxt = prod[gdd_pkg::RECIP_SHIFT +: gdd_pkg::QUOT_W];
      end
      gdd_pkg::OP_LEAP: begin
        // divisible by 4, and either not by 100 or its hundreds by 4
        leap_nxt = (cur.year[1:0] == 2'b00) &&
                   ((cur.year != prod[gdd_pkg::YEAR_W-1:0]) || (t_r[1:0] == 2'b00));
      end
      gdd_pkg::OP_MON: begin
        bad_nxt = bad_r | ~date_ok;
        term    = gdd_pkg::TERM_W'(gdd_pkg::days_before(cur.month))
                + gdd_pkg::TERM_W'(leap_r && (cur.month > 4'd2))
                + gdd_pkg::TERM_W'(cur.day) - 23'd1;
        add_en  = 1'b1;
      end
      gdd_pkg::OP_Y365: begin
        term   = prod[gdd_pkg::TERM_W-1:0]
               + gdd_pkg::TERM_W'(y_plus_99[gdd_pkg::MUL_A_W-1:0] - 15'd96 >> 2);
        add_en = 1'b1;
      end
      gdd_pkg::OP_ACCT: begin
        term   = gdd_pkg::TERM_W'(t_r);
        add_en = 1'b1;
      end
      default: begin
        term   = '0;
        add_en = 1'b0;
      end
    endcase
    if (add_en) begin
      if (uword.neg) begin
        acc_nxt = acc_r - $signed({1'b0, term});
      end else begin
        acc_nxt = acc_r + $signed({1'b0, term});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      acc_r  <= '0;
      bad_r  <= 1'b0;
      leap_r <= 1'b0;
      t_r    <= '0;
    end else if (exec) begin
      acc_r  <= acc_nxt;
      bad_r  <= bad_nxt;
      leap_r <= leap_nxt;
      t_r    <= t_nxt;
    end
  end

  // clamp negative difference, add flag, saturate; zero count on a bad date
  assign pos_diff = (acc_r > 0) ? acc_r : '0;
  assign sum      = pos_diff + gdd_pkg::ACC_W'(include_end_day);

  always_comb begin
    if (bad_r) begin
      count = '0;
    end else if (sum > gdd_pkg::COUNT_MAX) begin
      count = gdd_pkg::COUNT_MAX[gdd_pkg::COUNT_W-1:0];
    end else begin
      count = sum[gdd_pkg::COUNT_W-1:0];
    end
  end

  assign bad = bad_r;

endmodule

// ===== rtl/gregorian_date_difference.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_difference
// Days from a start date to an end date in the proleptic Gregorian calendar.
// ----------------------------------------------------------------------------
// usage:
//   input channel in_*: two dates (year, month, day) and include_end_day.
//   a transfer happens when in_valid is high and in_stall is low.
//   result channel out_*: day_count and invalid_date, one result per item.
//   day_count is end serial minus start serial, clamped at 0, plus one when
//   include_end_day is set, saturated at 4194303.
//   invalid_date is set (day_count 0) on a month outside 1..12 or a day of 0
//   or past the end of its month, leap years by the 400/100/4 rule.
// sequencing:
//   a microcoded sequencer runs 17 control steps per item on one shared
//   constant multiplier; the result shows on out_valid after the final step
//   and in_stall stays high until then, so a new item is not taken before
//   the last one has moved into the output register.
//   an invalid date jumps from the seventh step to the final one.
// reset: rst_n low clears the sequencer and empties the output register.
// stall: the output register holds its result while out_stall is high; a new
//   item may be taken meanwhile, its final step waits for the register.
// ----------------------------------------------------------------------------
module gregorian_date_difference (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [13:0] in_start_year,
  input  logic [3:0]  in_start_month,
  input  logic [4:0]  in_start_day,
  input  logic [13:0] in_end_year,
  input  logic [3:0]  in_end_month,
  input  logic [4:0]  in_end_day,
  input  logic        in_include_end_day,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [21:0] out_day_count,
  output logic        out_invalid_date
);

  // sequencer state
  logic                           busy_r, busy_nxt;
  logic [gdd_pkg::STEP_W-1:0]     step_r, step_nxt;
  gdd_pkg::uword_t                uword;

  // captured item
  gdd_pkg::date_t                 start_r, end_r;
  logic                           inc_r;

  // output register
  logic                           out_valid_r, out_valid_nxt;
  logic [gdd_pkg::COUNT_W-1:0]    out_day_count_r;
  logic                           out_invalid_date_r;

  logic                           in_xfer;
  logic                           out_xfer;
  logic                           fin_go;
  logic                           dp_bad;
  logic [gdd_pkg::COUNT_W-1:0]    dp_count;

  assign in_stall = busy_r;
  assign in_xfer  = in_valid & ~busy_r;
  assign out_xfer = out_valid_r & ~out_stall;

  // final step fires once the output register is free or being emptied
  assign fin_go = busy_r && (uword.op == gdd_pkg::OP_FIN) && (!out_valid_r || !out_stall);

  gdd_ucode_rom u_rom (
    .step  (step_r),
    .uword (uword)
  );

  gdd_datapath u_dp (
    .clk             (clk),
    .init            (in_xfer),
    .exec            (busy_r),
    .uword           (uword),
    .start_date      (start_r),
    .end_date        (end_r),
    .include_end_day (inc_r),
    .bad             (dp_bad),
    .count           (dp_count)
  );

  // step counter with conditional jump
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (in_xfer) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      if (uword.op == gdd_pkg::OP_FIN) begin
        if (fin_go) begin
          busy_nxt = 1'b0;
        end
      end else if (uword.jc == gdd_pkg::JC_BAD && dp_bad) begin
        step_nxt = uword.target;
      end else begin
        step_nxt = step_r + 5'd1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      start_r.year  <= in_start_year;
      start_r.month <= in_start_month;
      start_r.day   <= in_start_day;
      end_r.year    <= in_end_year;
      end_r.month   <= in_end_month;
      end_r.day     <= in_end_day;
      inc_r         <= in_include_end_day;
    end
    if (fin_go) begin
      out_day_count_r    <= dp_count;
      out_invalid_date_r <= dp_bad;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_day_count    = out_day_count_r;
  assign out_invalid_date = out_invalid_date_r;

  // an accepted item starts the program at its first step
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (busy_r && step_r == '0))
    else $error("sequencer did not start on input transfer");

  // step counter never runs past the final step
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r <= gdd_pkg::STEP_FIN))
    else $error("step counter out of range");

  // a new result only comes from a running sequencer
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r))
    else $error("result appeared without an item in work");

  // an invalid date always reports a zero count
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_invalid_date_r) |-> (out_day_count_r == '0))
    else $error("invalid date with nonzero count");

endmodule

// ===== dv/gdd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdd_checker
// Watches both channels of the date difference block, works out the day
// count for every input transfer and compares it with the result transfers.
// ----------------------------------------------------------------------------
module gdd_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [gdd_pkg::YEAR_W-1:0]  in_start_year,
  input  logic [gdd_pkg::MONTH_W-1:0] in_start_month,
  input  logic [gdd_pkg::DAY_W-1:0]   in_start_day,
  input  logic [gdd_pkg::YEAR_W-1:0]  in_end_year,
  input  logic [gdd_pkg::MONTH_W-1:0] in_end_month,
  input  logic [gdd_pkg::DAY_W-1:0]   in_end_day,
  input  logic                        in_include_end_day,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [gdd_pkg::COUNT_W-1:0] out_day_count,
  input  logic                        out_invalid_date,
  output int                          err_count,
  output int                          pending
);

  typedef struct packed {
    logic [gdd_pkg::COUNT_W-1:0] day_count;
    logic                        invalid_date;
  } span_t;

  span_t span_q[$];

  function automatic bit is_leap(input int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  // 0 for a month outside 1..12, so that any day fails the range check
  function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
    int unsigned n;
    case (m)
      2: n = is_leap(y) ? 29 : 28;
      4, 6, 9, 11: n = 30;
      1, 3, 5, 7, 8, 10, 12: n = 31;
      default: n = 0;
    endcase
    return n;
  endfunction

  // days since 0000-01-01
  function automatic int unsigned day_serial(input gdd_pkg::date_t dt);
    int unsigned y;
    int unsigned s;
    y = 32'(dt.year);
    s = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int unsigned k = 1; k < 32'(dt.month); k++)
      s += days_in_month(y, k);
    return s + 32'(dt.day) - 1;
  endfunction

  function automatic bit date_valid(input gdd_pkg::date_t dt);
    return (32'(dt.day) >= 1) &&
           (32'(dt.day) <= days_in_month(32'(dt.year), 32'(dt.month)));
  endfunction

  function automatic span_t predict_span(input gdd_pkg::date_t s, input gdd_pkg::date_t e,
                                         input logic inc);
    span_t r;
    int unsigned a;
    int unsigned b;
    int unsigned n;
    r = '0;
    if (!date_valid(s) || !date_valid(e)) begin
      r.invalid_date = 1'b1;
    end else begin
      a = day_serial(s);
      b = day_serial(e);
      n = (b > a) ? b - a : 0;
      n += 32'(inc);
      if (n > 32'(gdd_pkg::COUNT_MAX))
        n = 32'(gdd_pkg::COUNT_MAX);
      r.day_count = n[gdd_pkg::COUNT_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    gdd_pkg::date_t s;
    gdd_pkg::date_t e;
    span_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        s = '{year: in_start_year, month: in_start_month, day: in_start_day};
        e = '{year: in_end_year, month: in_end_month, day: in_end_day};
        span_q.push_back(predict_span(s, e, in_include_end_day));
      end
      if (out_valid && !out_stall) begin
        if (span_q.size() == 0) begin
          $error("result transfer with nothing expected: day_count %0d invalid_date %0b",
                 out_day_count, out_invalid_date);
          err_count++;
        end else begin
          want = span_q.pop_front();
          if (out_day_count !== want.day_count) begin
            $error("day_count expected %0d actual %0d", want.day_count, out_day_count);
            err_count++;
          end
          if (out_invalid_date !== want.invalid_date) begin
            $error("invalid_date expected %0b actual %0b", want.invalid_date,
                   out_invalid_date);
            err_count++;
          end
        end
      end
      pending = span_q.size();
    end else begin
      span_q.delete();
      err_count = 0;
      pending   = 0;
    end
  end

endmodule

// ===== dv/gregorian_date_difference_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_difference_tb
// Drives date pairs into the date difference block: a directed set of
// calendar corner cases, then random pairs, with random idle and stall
// bursts and one long output hold-off. A checker beside the block predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module gregorian_date_difference_tb;

  localparam int RANDOM_ITEMS = 1580;
  localparam int QUIET_ITEMS  = 200;   // tail of the run with no idling at all
  localparam int HOLD_AT      = 400;   // transfer count that triggers the hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [gdd_pkg::YEAR_W-1:0]  in_start_year;
  logic [gdd_pkg::MONTH_W-1:0] in_start_month;
  logic [gdd_pkg::DAY_W-1:0]   in_start_day;
  logic [gdd_pkg::YEAR_W-1:0]  in_end_year;
  logic [gdd_pkg::MONTH_W-1:0] in_end_month;
  logic [gdd_pkg::DAY_W-1:0]   in_end_day;
  logic                        in_include_end_day;
  logic                        out_valid;
  logic                        out_stall;
  logic [gdd_pkg::COUNT_W-1:0] out_day_count;
  logic                        out_invalid_date;

  int err_count;
  int pending;
  int sent_count;
  bit quiet;       // no idle or stall bursts once set
  bit hold_req;    // asks the receiver for its long hold-off

  gregorian_date_difference u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_start_year     (in_start_year),
    .in_start_month    (in_start_month),
    .in_start_day      (in_start_day),
    .in_end_year       (in_end_year),
    .in_end_month      (in_end_month),
    .in_end_day        (in_end_day),
    .in_include_end_day(in_include_end_day),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_day_count     (out_day_count),
    .out_invalid_date  (out_invalid_date)
  );

  gdd_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_start_year     (in_start_year),
    .in_start_month    (in_start_month),
    .in_start_day      (in_start_day),
    .in_end_year       (in_end_year),
    .in_end_month      (in_end_month),
    .in_end_day        (in_end_day),
    .in_include_end_day(in_include_end_day),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_day_count     (out_day_count),
    .out_invalid_date  (out_invalid_date),
    .err_count         (err_count),
    .pending           (pending)
  );

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // one date pair per transfer; inputs move only on the falling edge
  task automatic send_dates(input int unsigned sy, input int unsigned sm, input int unsigned sd,
                            input int unsigned ey, input int unsigned em, input int unsigned ed,
                            input int unsigned inc);
    int unsigned gap;
    // random idle burst ahead of the item, junk on the bus meanwhile
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_valid      = 1'b0;
      in_start_year = gdd_pkg::YEAR_W'($urandom_range(0, 16383));
      in_end_day    = gdd_pkg::DAY_W'($urandom_range(0, 31));
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid           = 1'b1;
    in_start_year      = sy[gdd_pkg::YEAR_W-1:0];
    in_start_month     = sm[gdd_pkg::MONTH_W-1:0];
    in_start_day       = sd[gdd_pkg::DAY_W-1:0];
    in_end_year        = ey[gdd_pkg::YEAR_W-1:0];
    in_end_month       = em[gdd_pkg::MONTH_W-1:0];
    in_end_day         = ed[gdd_pkg::DAY_W-1:0];
    in_include_end_day = inc[0];
    // hold the payload until the block takes it
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (sent_count == HOLD_AT)
      hold_req = 1'b1;
  endtask

  // mostly short-month-safe days, now and then up to 31 to hit month ends
  task automatic pick_date(output gdd_pkg::date_t dt, input int unsigned ylo,
                           input int unsigned yhi);
    dt.year  = gdd_pkg::YEAR_W'($urandom_range(ylo, yhi));
    dt.month = gdd_pkg::MONTH_W'($urandom_range(1, 12));
    dt.day   = gdd_pkg::DAY_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 31)
                                                           : $urandom_range(1, 28));
  endtask

  // receiver: random stall bursts, quiet stretches, and one long hold-off
  // while the sender keeps offering so that the block backs up into in_stall
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end else begin
        out_stall = 1'b0;
        if (!quiet)
          repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  // watchdog
  initial begin
    #10ms;
    $display("gregorian_date_difference_tb: done, errors");
    $finish;
  end

  initial begin
    gdd_pkg::date_t s;
    gdd_pkg::date_t e;
    int unsigned kind;
    int unsigned inc;

    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_start_year      = '0;
    in_start_month     = '0;
    in_start_day       = '0;
    in_end_year        = '0;
    in_end_month       = '0;
    in_end_day         = '0;
    in_include_end_day = 1'b0;
    sent_count         = 0;
    quiet              = 1'b0;
    hold_req           = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // ---- directed corners ----
    // equal dates, without and with the end day
    send_dates(2000, 1, 1, 2000, 1, 1, 0);
    send_dates(2000, 1, 1, 2000, 1, 1, 1);
    // first date later than the second: clamps to zero, then the flag adds one
    send_dates(2000, 3, 1, 2000, 2, 28, 0);
    send_dates(2000, 3, 1, 2000, 2, 28, 1);
    // century rules around the end of february
    send_dates(1900, 2, 28, 1900, 3, 1, 0);
    send_dates(2000, 2, 28, 2000, 3, 1, 0);
    send_dates(2000, 2, 29, 2400, 2, 29, 1);
    send_dates(1900, 2, 29, 1901, 1, 1, 0);
    send_dates(2001, 2, 29, 2002, 1, 1, 0);
    send_dates(2004, 1, 1, 2100, 2, 29, 0);
    // month out of range in either date
    send_dates(2020, 0, 10, 2021, 5, 5, 1);
    send_dates(2020, 5, 10, 2021, 13, 5, 0);
    send_dates(2020, 15, 10, 2021, 5, 5, 0);
    // day zero and day past month end
    send_dates(2020, 5, 0, 2021, 5, 5, 0);
    send_dates(2020, 4, 31, 2021, 5, 5, 1);
    send_dates(2020, 12, 31, 2021, 6, 31, 0);
    send_dates(1999, 12, 31, 2000, 1, 1, 0);
    // year zero is leap; the widest span in range
    send_dates(0, 2, 29, 1, 1, 1, 0);
    send_dates(1, 1, 1, 9999, 12, 31, 1);
    send_dates(9999, 12, 31, 1, 1, 1, 1);
    send_dates(9999, 12, 31, 10000, 1, 1, 0);
    // count saturation needs years past 9999
    send_dates(0, 1, 1, 16383, 12, 31, 1);
    send_dates(1, 1, 1, 16383, 12, 31, 0);
    // all-ones and all-zeros buses
    send_dates(16383, 15, 31, 16383, 15, 31, 1);
    send_dates(0, 0, 0, 0, 0, 0, 0);

    // ---- random pairs ----
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_ITEMS)
        quiet = 1'b1;
      kind = $urandom_range(0, 19);
      inc  = $urandom_range(0, 1);
      if (kind < 12) begin
        // well-formed pairs spread over the usual year range
        pick_date(s, 1, 9999);
        pick_date(e, 1, 9999);
      end else if (kind < 15) begin
        // close dates: small counts and either order
        pick_date(s, 1, 9999);
        pick_date(e, 1, 9999);
        e.year = s.year + gdd_pkg::YEAR_W'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 0) begin
          gdd_pkg::date_t t;
          t = s;
          s = e;
          e = t;
        end
      end else if (kind < 17) begin
        // the whole year field, including year zero and past 9999
        pick_date(s, 0, 16383);
        pick_date(e, 0, 16383);
      end else begin
        // raw bits, mostly rejected dates
        s.year  = gdd_pkg::YEAR_W'($urandom_range(0, 16383));
        s.month = gdd_pkg::MONTH_W'($urandom_range(0, 15));
        s.day   = gdd_pkg::DAY_W'($urandom_range(0, 31));
        e.year  = gdd_pkg::YEAR_W'($urandom_range(0, 16383));
        e.month = gdd_pkg::MONTH_W'($urandom_range(0, 15));
        e.day   = gdd_pkg::DAY_W'($urandom_range(0, 31));
      end
      send_dates(s.year, s.month, s.day, e.year, e.month, e.day, inc);
    end

    @(negedge clk);
    in_valid = 1'b0;

    // drain, then leave room for any stray result
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_count == 0)
      $display("gregorian_date_difference_tb: done, clean");
    else
      $display("gregorian_date_difference_tb: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gdd_pkg.sv
rtl/gdd_ucode_rom.sv
rtl/gdd_datapath.sv
rtl/gregorian_date_difference.sv
dv/gdd_checker.sv
dv/gregorian_date_difference_tb.sv
